[rtl/hdlp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdlp_pkg: shared types and constants
// Transaction payloads, parse state and character codes for the literal parser.
// ----------------------------------------------------------------------------
package hdlp_pkg;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic [63:0] value;
      logic        ok;
      logic        was_hex;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  char_position;
      logic        hex_mode;
      logic [63:0] accumulator;
      logic        digit_seen;
      logic        invalid_seen;
   } parse_state_type;

   localparam parse_state_type PARSE_STATE_RESET = '0;

   // character position saturates here
   localparam logic [1:0] POS_FIRST  = 2'd0;
   localparam logic [1:0] POS_SECOND = 2'd1;
   localparam logic [1:0] POS_SAT    = 2'd2;

   localparam logic [7:0] CHAR_ZERO       = 8'h30;
   localparam logic [7:0] CHAR_NINE       = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A    = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F    = 8'h46;
   localparam logic [7:0] CHAR_LOWER_A    = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F    = 8'h66;
   localparam logic [7:0] CHAR_UPPER_X    = 8'h58;
   localparam logic [7:0] CHAR_LOWER_X    = 8'h78;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

   localparam logic [35:0] DEC_LIMIT      = 36'd2147483647;
   localparam logic [63:0] DEC_LIMIT_WIDE = 64'd2147483647;

endpackage

[rtl/hdlp_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdlp_step: one-character parse step
// Next parse state and the result a final character would produce.
// ----------------------------------------------------------------------------
module hdlp_step (
   input  hdlp_pkg::parse_state_type state_cur,
   input  logic [7:0]                char_code,
   output hdlp_pkg::parse_state_type state_nxt,
   output hdlp_pkg::rsp_type         result
);
   import hdlp_pkg::*;

   logic        prefix_x;
   logic        take_prefix;
   logic        is_dec;
   logic        is_upper_hex;
   logic        is_lower_hex;
   logic        is_hex;
   logic [3:0]  hex_val;
   logic [35:0] acc_narrow;
   logic [35:0] dec_next;
   logic        ok;

   always_comb begin
      prefix_x     = (char_code == CHAR_LOWER_X) || (char_code == CHAR_UPPER_X);
      take_prefix  = !state_cur.hex_mode && (state_cur.char_position == POS_SECOND) &&
                     prefix_x && state_cur.digit_seen &&
                     (state_cur.accumulator == 64'd0) && !state_cur.invalid_seen;
      is_dec       = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
      is_upper_hex = (char_code >= CHAR_UPPER_A) && (char_code <= CHAR_UPPER_F);
      is_lower_hex = (char_code >= CHAR_LOWER_A) && (char_code <= CHAR_LOWER_F);
      is_hex       = is_dec || is_upper_hex || is_lower_hex;
      // letters: low nibble 1..6 maps to 10..15
      hex_val      = is_dec ? char_code[3:0] : (char_code[3:0] + 4'd9);

      // decimal mode keeps the accumulator within 31 bits: x10 via shifts
      acc_narrow   = {4'd0, state_cur.accumulator[31:0]};
      dec_next     = (acc_narrow << 3) + (acc_narrow << 1) + {32'd0, char_code[3:0]};

      state_nxt = state_cur;
      state_nxt.char_position = (state_cur.char_position == POS_SAT) ?
                                POS_SAT : (state_cur.char_position + 2'd1);

      priority if (take_prefix) begin
         state_nxt.hex_mode    = 1'b1;
         state_nxt.accumulator = 64'd0;
         state_nxt.digit_seen  = 1'b0;
      end else if (char_code == CHAR_UNDERSCORE) begin
         state_nxt.invalid_seen = state_cur.invalid_seen;
      end else if (state_cur.hex_mode) begin
         priority if (!is_hex) begin
            state_nxt.invalid_seen = 1'b1;
         end else if (|state_cur.accumulator[63:60]) begin
            state_nxt.invalid_seen = 1'b1;
            state_nxt.digit_seen   = 1'b1;
         end else begin
            state_nxt.accumulator = {state_cur.accumulator[59:0], hex_val};
            state_nxt.digit_seen  = 1'b1;
         end
      end else if (is_dec) begin
         state_nxt.digit_seen = 1'b1;
         if (dec_next > DEC_LIMIT) begin
            state_nxt.invalid_seen = 1'b1;
         end else begin
            state_nxt.accumulator = {32'd0, dec_next[31:0]};
         end
      end else begin
         state_nxt.invalid_seen = 1'b1;
      end

      ok             = state_nxt.digit_seen && !state_nxt.invalid_seen;
      result.value   = ok ? state_nxt.accumulator : 64'd0;
      result.ok      = ok;
      result.was_hex = state_nxt.hex_mode;
   end

endmodule

[rtl/hdlp_out_buf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hdlp_out_buf: result skid buffer
// Output register plus one skid entry; keeps ready off the downstream path.
// ----------------------------------------------------------------------------
module hdlp_out_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  hdlp_pkg::rsp_type push_data,
   output logic              can_push,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hdlp_pkg::rsp_type rsp_data
);
   import hdlp_pkg::*;

   logic    main_valid_ff;
   logic    main_valid_in;
   rsp_type main_ff;
   logic    skid_valid_ff;
   logic    skid_valid_in;
   rsp_type skid_ff;

   assign can_push  = !skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (main_valid_ff && !rsp_ready) begin
         if (push) begin
            skid_valid_in = 1'b1;
         end
      end else if (skid_valid_ff) begin
         main_valid_in = 1'b1;
         skid_valid_in = 1'b0;
      end else begin
         main_valid_in = push;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (main_valid_ff && !rsp_ready) begin
         if (push) begin
            skid_ff <= push_data;
         end
      end else if (skid_valid_ff) begin
         main_ff <= skid_ff;
      end else if (push) begin
         main_ff <= push_data;
      end
   end

`ifndef ASSERT_OFF
   a_skid_needs_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry held without a result in the output register");
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> can_push)
      else $error("result pushed while skid entry occupied");
   a_drain_skid: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp_ready) |=> !skid_valid_ff)
      else $error("skid entry not moved on after output taken");
`endif

endmodule

[rtl/hex_or_decimal_literal_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_or_decimal_literal_parser: streaming number literal parser
// Takes ASCII characters one per transaction, returns one result per literal.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one character per transaction (char_code, last_char). A
//     literal is any run of characters ending in one with last_char set.
//   rsp_ channel: one transaction per literal, on its last character:
//     value, ok and was_hex. A failed parse returns ok 0 and value 0.
//   "0x"/"0X" as the first two characters selects hex (up to 64 bits);
//     otherwise decimal, capped at 2147483647. Underscores are skipped.
//   Result path: the parse step lies between the input register and the
//     result register, which drives rsp_valid and rsp_data.
//   Throughput: one character per cycle, unless a final character is
//     stalled; the parse step (a x10 shift-add or a 4-bit shift) lies
//     between the input register and the parse state register.
//   Reset: synchronous, clears the parse state and empties all stages.
//   Stall: a result waits in the output register, with one skid entry
//     behind it; characters keep flowing, and only a final character
//     stalls when both the output register and the skid entry are full.
// ----------------------------------------------------------------------------
module hex_or_decimal_literal_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  hdlp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hdlp_pkg::rsp_type rsp_data
);
   import hdlp_pkg::*;

   // input register
   logic            in_valid_ff;
   logic            in_valid_in;
   req_type         in_data_ff;

   // parse state, carried across the characters of one literal
   parse_state_type state_ff;
   parse_state_type state_in;
   parse_state_type state_nxt;

   rsp_type         step_result;
   logic            buf_can_push;
   logic            step_fire;
   logic            result_push;
   logic            req_accept;

   hdlp_step u_step (
      .state_cur (state_ff),
      .char_code (in_data_ff.char_code),
      .state_nxt (state_nxt),
      .result    (step_result)
   );

   // A final character may only advance when the result buffer has room.
   assign step_fire   = in_valid_ff && (!in_data_ff.last_char || buf_can_push);
   assign result_push = step_fire && in_data_ff.last_char;
   assign req_ready   = !in_valid_ff || step_fire;
   assign req_accept  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (step_fire) begin
         in_valid_in = 1'b0;
      end
      state_in = state_ff;
      if (step_fire) begin
         // state returns to its reset value after each literal
         state_in = in_data_ff.last_char ? PARSE_STATE_RESET : state_nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= PARSE_STATE_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_data;
      end
   end

   hdlp_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (result_push),
      .push_data (step_result),
      .can_push  (buf_can_push),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef ASSERT_OFF
   a_dec_bound: assert property (@(posedge clock) disable iff (reset)
      !state_ff.hex_mode |-> (state_ff.accumulator <= DEC_LIMIT_WIDE))
      else $error("decimal accumulator above limit");
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      result_push |=> (state_ff == PARSE_STATE_RESET))
      else $error("parse state not cleared after final character");
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.ok) |-> (rsp_data.value == 64'd0))
      else $error("failed parse returned a non-zero value");
   a_pos_sat: assert property (@(posedge clock) disable iff (reset)
      state_ff.char_position != 2'd3)
      else $error("character position beyond saturation");
`endif

endmodule
